### hdl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

    localparam int QUAT_W    = 16;
    localparam int OUT_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_QUAT  = 4;
    localparam int NUM_AXES  = 3;

    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [OUT_W-1:0]  t_out;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // register indexes of the configuration port
    localparam t_cfg_idx REG_QUAT_W = 2'd0;
    localparam t_cfg_idx REG_QUAT_X = 2'd1;
    localparam t_cfg_idx REG_QUAT_Y = 2'd2;
    localparam t_cfg_idx REG_QUAT_Z = 2'd3;

    // quaternion component slots
    localparam int QW = 0;
    localparam int QX = 1;
    localparam int QY = 2;
    localparam int QZ = 3;

    // identity rotation in Q2.14
    localparam t_quat QUAT_W_RESET = 16'sd16384;
    localparam t_quat QUAT_V_RESET = 16'sd0;

    localparam t_out OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam t_out OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

### hdl/qvr_round_sat.sv
// Round half up, arithmetic shift and saturation of one rotated component.
`default_nettype none

module qvr_round_sat #(
    parameter int IN_W  = 70,
    parameter int SHIFT = 28
) (
    input  wire logic signed [IN_W-1:0] i_sum,
    output qvr_pkg::t_out               o_val,
    output logic                        o_clip
);

    localparam int EXT_W = (IN_W > SHIFT + qvr_pkg::OUT_W) ? IN_W + 1
                                                          : SHIFT + qvr_pkg::OUT_W + 1;
    localparam int SHR_W = EXT_W - SHIFT;
    localparam logic [EXT_W-1:0] ONE  = 1;
    localparam logic [EXT_W-1:0] HALF = ONE << (SHIFT - 1);

    logic signed [EXT_W-1:0] w_ext;
    logic        [EXT_W-1:0] w_rnd;
    logic        [SHR_W-1:0] w_shr;
    logic                    w_all_one;
    logic                    w_all_zero;

    always_comb begin
        w_ext      = EXT_W'(i_sum);
        w_rnd      = w_ext + HALF;
        w_shr      = w_rnd[EXT_W-1:SHIFT];
        // bits above the output sign must all copy it
        w_all_one  = &w_shr[SHR_W-1:qvr_pkg::OUT_W-1];
        w_all_zero = ~|w_shr[SHR_W-1:qvr_pkg::OUT_W-1];
        o_clip     = ~(w_all_one | w_all_zero);
        if (!o_clip) begin
            o_val = w_shr[qvr_pkg::OUT_W-1:0];
        end else if (w_shr[SHR_W-1]) begin
            o_val = qvr_pkg::OUT_MIN;
        end else begin
            o_val = qvr_pkg::OUT_MAX;
        end
    end

endmodule

`default_nettype wire

### hdl/quaternion_vector_rotate.sv
// Quaternion vector rotator: pipelined q * (0, v) * conj(q) with rounding and saturation.
//
// Usage:
//   Input channel i_valid/o_ready carries one vector (vec_x, vec_y, vec_z) per item.
//   Output channel o_valid/i_ready returns the rotated vector rot_x/y/z and a clipped
//   flag, set when any component saturated to the 18-bit signed range.
//   Configuration channel i_cfg_valid/o_cfg_ready writes quaternion register
//   i_cfg_index (0 = w, 1 = x, 2 = y, 3 = z) with i_cfg_data, signed Q2.14 by default.
//   Write configuration only while no item is in flight; o_cfg_ready is always high.
// Timing:
//   Five register stages: v*q products, conj product sums, q*p products, final sums,
//   round/saturate into the output register. While the receiver keeps i_ready high, one
//   item per cycle is sustained; the pipeline depth sets the latency and the multipliers
//   of each stage take one item every cycle.
// Reset (synchronous, active low): empties the pipeline and loads the identity
//   quaternion (w = 1.0). When the receiver stalls, each stage holds its item and
//   o_ready drops only once every stage is occupied, so nothing is lost or repeated.
`default_nettype none

module quaternion_vector_rotate #(
    parameter int VEC_WIDTH      = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // vector input
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic signed [VEC_WIDTH-1:0] i_vec_x,
    input  wire logic signed [VEC_WIDTH-1:0] i_vec_y,
    input  wire logic signed [VEC_WIDTH-1:0] i_vec_z,
    // rotated output
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output qvr_pkg::t_out                    o_rot_x,
    output qvr_pkg::t_out                    o_rot_y,
    output qvr_pkg::t_out                    o_rot_z,
    output logic                             o_clipped,
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire qvr_pkg::t_cfg_idx           i_cfg_index,
    input  wire qvr_pkg::t_quat              i_cfg_data
);

    localparam int NSTG  = 5;
    localparam int P1_W  = VEC_WIDTH + qvr_pkg::QUAT_W;
    localparam int P2_W  = P1_W + 2;
    localparam int P3_W  = P2_W + qvr_pkg::QUAT_W;
    localparam int SUM_W = P3_W + 2;
    localparam int SHIFT = 2 * QUAT_FRAC_BITS;

    // quaternion registers
    qvr_pkg::t_quat r_quat [qvr_pkg::NUM_QUAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[qvr_pkg::QW] <= qvr_pkg::QUAT_W_RESET;
            r_quat[qvr_pkg::QX] <= qvr_pkg::QUAT_V_RESET;
            r_quat[qvr_pkg::QY] <= qvr_pkg::QUAT_V_RESET;
            r_quat[qvr_pkg::QZ] <= qvr_pkg::QUAT_V_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qvr_pkg::REG_QUAT_W: r_quat[qvr_pkg::QW] <= i_cfg_data;
                qvr_pkg::REG_QUAT_X: r_quat[qvr_pkg::QX] <= i_cfg_data;
                qvr_pkg::REG_QUAT_Y: r_quat[qvr_pkg::QY] <= i_cfg_data;
                qvr_pkg::REG_QUAT_Z: r_quat[qvr_pkg::QZ] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // stage valid bits and per-stage advance enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = ~r_vld[NSTG-1] | i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: every vector component times every quaternion component
    logic signed [VEC_WIDTH-1:0] w_vec [qvr_pkg::NUM_AXES];
    logic signed [P1_W-1:0] n_m1 [qvr_pkg::NUM_AXES][qvr_pkg::NUM_QUAT];
    logic signed [P1_W-1:0] r_m1 [qvr_pkg::NUM_AXES][qvr_pkg::NUM_QUAT];

    always_comb begin
        w_vec[0] = i_vec_x;
        w_vec[1] = i_vec_y;
        w_vec[2] = i_vec_z;
        for (int i = 0; i < qvr_pkg::NUM_AXES; i++) begin
            for (int j = 0; j < qvr_pkg::NUM_QUAT; j++) begin
                n_m1[i][j] = w_vec[i] * r_quat[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_m1 <= n_m1;
        end
    end

    // stage 2: p = (0, v) * conj(q)
    logic signed [P2_W-1:0] n_p2 [qvr_pkg::NUM_QUAT];
    logic signed [P2_W-1:0] r_p2 [qvr_pkg::NUM_QUAT];

    always_comb begin
        n_p2[qvr_pkg::QW] = P2_W'(r_m1[0][qvr_pkg::QX]) + P2_W'(r_m1[1][qvr_pkg::QY])
                          + P2_W'(r_m1[2][qvr_pkg::QZ]);
        n_p2[qvr_pkg::QX] = P2_W'(r_m1[0][qvr_pkg::QW]) - P2_W'(r_m1[1][qvr_pkg::QZ])
                          + P2_W'(r_m1[2][qvr_pkg::QY]);
        n_p2[qvr_pkg::QY] = P2_W'(r_m1[0][qvr_pkg::QZ]) + P2_W'(r_m1[1][qvr_pkg::QW])
                          - P2_W'(r_m1[2][qvr_pkg::QX]);
        n_p2[qvr_pkg::QZ] = P2_W'(r_m1[1][qvr_pkg::QX]) + P2_W'(r_m1[2][qvr_pkg::QW])
                          - P2_W'(r_m1[0][qvr_pkg::QY]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p2 <= n_p2;
        end
    end

    // stage 3: the twelve products of q * p that feed the vector part
    logic signed [P3_W-1:0] n_m3 [qvr_pkg::NUM_AXES][qvr_pkg::NUM_QUAT];
    logic signed [P3_W-1:0] r_m3 [qvr_pkg::NUM_AXES][qvr_pkg::NUM_QUAT];

    always_comb begin
        n_m3[0][0] = r_quat[qvr_pkg::QW] * r_p2[qvr_pkg::QX];
        n_m3[0][1] = r_quat[qvr_pkg::QX] * r_p2[qvr_pkg::QW];
        n_m3[0][2] = r_quat[qvr_pkg::QY] * r_p2[qvr_pkg::QZ];
        n_m3[0][3] = r_quat[qvr_pkg::QZ] * r_p2[qvr_pkg::QY];
        n_m3[1][0] = r_quat[qvr_pkg::QW] * r_p2[qvr_pkg::QY];
        n_m3[1][1] = r_quat[qvr_pkg::QX] * r_p2[qvr_pkg::QZ];
        n_m3[1][2] = r_quat[qvr_pkg::QY] * r_p2[qvr_pkg::QW];
        n_m3[1][3] = r_quat[qvr_pkg::QZ] * r_p2[qvr_pkg::QX];
        n_m3[2][0] = r_quat[qvr_pkg::QW] * r_p2[qvr_pkg::QZ];
        n_m3[2][1] = r_quat[qvr_pkg::QX] * r_p2[qvr_pkg::QY];
        n_m3[2][2] = r_quat[qvr_pkg::QY] * r_p2[qvr_pkg::QX];
        n_m3[2][3] = r_quat[qvr_pkg::QZ] * r_p2[qvr_pkg::QW];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_m3 <= n_m3;
        end
    end

    // stage 4: full-precision sums of the vector part
    logic signed [SUM_W-1:0] n_s4 [qvr_pkg::NUM_AXES];
    logic signed [SUM_W-1:0] r_s4 [qvr_pkg::NUM_AXES];

    always_comb begin
        n_s4[0] = SUM_W'(r_m3[0][0]) + SUM_W'(r_m3[0][1])
                + SUM_W'(r_m3[0][2]) - SUM_W'(r_m3[0][3]);
        n_s4[1] = SUM_W'(r_m3[1][0]) - SUM_W'(r_m3[1][1])
                + SUM_W'(r_m3[1][2]) + SUM_W'(r_m3[1][3]);
        n_s4[2] = SUM_W'(r_m3[2][0]) + SUM_W'(r_m3[2][1])
                - SUM_W'(r_m3[2][2]) + SUM_W'(r_m3[2][3]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4 <= n_s4;
        end
    end

    // stage 5: round, shift, saturate into the output register
    qvr_pkg::t_out          w_val  [qvr_pkg::NUM_AXES];
    logic [qvr_pkg::NUM_AXES-1:0] w_clip;
    qvr_pkg::t_out          r_rot  [qvr_pkg::NUM_AXES];
    logic                   r_clip;

    for (genvar g = 0; g < qvr_pkg::NUM_AXES; g++) begin : g_sat
        qvr_round_sat #(
            .IN_W  (SUM_W),
            .SHIFT (SHIFT)
        ) u_sat (
            .i_sum  (r_s4[g]),
            .o_val  (w_val[g]),
            .o_clip (w_clip[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_rot  <= w_val;
            r_clip <= |w_clip;
        end
    end

    assign o_rot_x   = r_rot[0];
    assign o_rot_y   = r_rot[1];
    assign o_rot_z   = r_rot[2];
    assign o_clipped = r_clip;

    // checks
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_en[2]) |=> (r_vld[2] && $stable(r_m3[0][0])))
        else $error("stalled stage lost or changed its item");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
        (o_rot_x == qvr_pkg::OUT_MAX || o_rot_x == qvr_pkg::OUT_MIN ||
         o_rot_y == qvr_pkg::OUT_MAX || o_rot_y == qvr_pkg::OUT_MIN ||
         o_rot_z == qvr_pkg::OUT_MAX || o_rot_z == qvr_pkg::OUT_MIN))
        else $error("clipped flag set with no component at a rail");

    a_reset_identity: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_quat[qvr_pkg::QW] == qvr_pkg::QUAT_W_RESET && r_vld == '0))
        else $error("reset did not load identity and empty the pipeline");

endmodule

`default_nettype wire

### test/tb_quaternion_vector_rotate.sv
`timescale 1ns / 100ps
// Self-checking bench for the quaternion vector rotator: directed table, then random phases.
module tb_quaternion_vector_rotate;

    localparam int VEC_W        = 16;
    localparam int FRAC         = 14;
    localparam int IDLE_PCT     = 34;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 163;
    localparam int STEADY_PHASE = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [VEC_W-1:0] t_vec;

    typedef struct packed {
        qvr_pkg::t_out x;
        qvr_pkg::t_out y;
        qvr_pkg::t_out z;
        logic          clipped;
    } t_rot;

    typedef struct {
        qvr_pkg::t_quat qw, qx, qy, qz;
        t_vec           vx, vy, vz;
        bit             typed;
        t_rot           want;
    } t_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_ready     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    t_vec              i_vec_x     = '0;
    t_vec              i_vec_y     = '0;
    t_vec              i_vec_z     = '0;
    qvr_pkg::t_cfg_idx i_cfg_index = qvr_pkg::REG_QUAT_W;
    qvr_pkg::t_quat    i_cfg_data  = '0;
    logic              o_ready, o_valid, o_clipped, o_cfg_ready;
    qvr_pkg::t_out     o_rot_x, o_rot_y, o_rot_z;

    qvr_pkg::t_quat quat_regs [qvr_pkg::NUM_QUAT];
    t_rot  rot_expected [$];
    t_row  dir_rows [$];
    bit    steady = 1'b0;
    int    mismatches = 0;
    int    quiet_cycles = 0;

    quaternion_vector_rotate #(
        .VEC_WIDTH      (VEC_W),
        .QUAT_FRAC_BITS (FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z),
        .o_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // floor((s + 2^(2F-1)) / 2^(2F))
    function automatic longint round_half_up(input longint acc);
        return (acc + (64'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
    endfunction

    function automatic qvr_pkg::t_out saturate(input longint val);
        if (val > qvr_pkg::OUT_MAX)
            return qvr_pkg::OUT_MAX;
        if (val < qvr_pkg::OUT_MIN)
            return qvr_pkg::OUT_MIN;
        return val[qvr_pkg::OUT_W-1:0];
    endfunction

    // q * (0, v) * conj(q), vector part, exact in 64 bits at these widths
    function automatic t_rot predict_rotation(input t_vec vx, input t_vec vy, input t_vec vz);
        longint qw, qx, qy, qz, x, y, z, pw, px, py, pz, sx, sy, sz;
        t_rot r;
        qw = longint'(quat_regs[qvr_pkg::REG_QUAT_W]);
        qx = longint'(quat_regs[qvr_pkg::REG_QUAT_X]);
        qy = longint'(quat_regs[qvr_pkg::REG_QUAT_Y]);
        qz = longint'(quat_regs[qvr_pkg::REG_QUAT_Z]);
        x = longint'(vx);
        y = longint'(vy);
        z = longint'(vz);
        pw = x * qx + y * qy + z * qz;
        px = x * qw - y * qz + z * qy;
        py = x * qz + y * qw - z * qx;
        pz = y * qx - x * qy + z * qw;
        sx = round_half_up(qw * px + qx * pw + qy * pz - qz * py);
        sy = round_half_up(qw * py - qx * pz + qy * pw + qz * px);
        sz = round_half_up(qw * pz + qx * py - qy * px + qz * pw);
        r.x = saturate(sx);
        r.y = saturate(sy);
        r.z = saturate(sz);
        r.clipped = (sx != r.x) || (sy != r.y) || (sz != r.z);
        return r;
    endfunction

    function automatic qvr_pkg::t_quat random_component(input int mode);
        case (mode)
            0: return qvr_pkg::t_quat'($urandom);
            1: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h4000;
                    3: return 16'hC000;
                    default: return 16'h0000;
                endcase
            end
            // keep |q|^2 at or below one so most results stay in range
            default: return qvr_pkg::t_quat'(int'($urandom_range(16383)) - 8192);
        endcase
    endfunction

    function automatic t_vec random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return t_vec'($urandom);
        if (pick < 90)
            return t_vec'(int'($urandom_range(511)) - 256);
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic add_row(input int qw, input int qx, input int qy, input int qz,
                           input int vx, input int vy, input int vz, input bit typed,
                           input int ex, input int ey, input int ez, input bit ec);
        t_row row;
        row.qw = qvr_pkg::t_quat'(qw);
        row.qx = qvr_pkg::t_quat'(qx);
        row.qy = qvr_pkg::t_quat'(qy);
        row.qz = qvr_pkg::t_quat'(qz);
        row.vx = t_vec'(vx);
        row.vy = t_vec'(vy);
        row.vz = t_vec'(vz);
        row.typed = typed;
        row.want.x = qvr_pkg::t_out'(ex);
        row.want.y = qvr_pkg::t_out'(ey);
        row.want.z = qvr_pkg::t_out'(ez);
        row.want.clipped = ec;
        dir_rows.push_back(row);
    endtask

    task automatic write_register(input qvr_pkg::t_cfg_idx idx, input qvr_pkg::t_quat data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        quat_regs[idx] = data;
    endtask

    // drain the pipeline, then rewrite all four registers
    task automatic load_quaternion(input qvr_pkg::t_quat qw, input qvr_pkg::t_quat qx,
                                   input qvr_pkg::t_quat qy, input qvr_pkg::t_quat qz);
        i_valid <= 1'b0;
        while (rot_expected.size() != 0)
            @(posedge i_clk);
        write_register(qvr_pkg::REG_QUAT_W, qw);
        write_register(qvr_pkg::REG_QUAT_X, qx);
        write_register(qvr_pkg::REG_QUAT_Y, qy);
        write_register(qvr_pkg::REG_QUAT_Z, qz);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_vector(input t_vec vx, input t_vec vy, input t_vec vz,
                               input bit typed, input t_rot want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        do @(posedge i_clk); while (!o_ready);
        rot_expected.push_back(typed ? want : predict_rotation(vx, vy, vz));
    endtask

    task automatic note_mismatch(input string what, input t_rot want, input t_rot got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: exp x=%0d y=%0d z=%0d clip=%0b, got x=%0d y=%0d z=%0d clip=%0b",
                     what, want.x, want.y, want.z, want.clipped,
                     got.x, got.y, got.z, got.clipped);
    endtask

    always @(posedge i_clk)
        i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin : check_results
        t_rot got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got.x = o_rot_x;
            got.y = o_rot_y;
            got.z = o_rot_z;
            got.clipped = o_clipped;
            if (rot_expected.size() == 0) begin
                note_mismatch("result with nothing pending", got, got);
            end else begin
                want = rot_expected.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                        || got.clipped !== want.clipped)
                    note_mismatch("rotation mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_row           row;
        qvr_pkg::t_quat q [qvr_pkg::NUM_QUAT];
        t_rot           none;
        int             mode;

        none = '0;
        quat_regs[qvr_pkg::REG_QUAT_W] = qvr_pkg::QUAT_W_RESET;
        quat_regs[qvr_pkg::REG_QUAT_X] = qvr_pkg::QUAT_V_RESET;
        quat_regs[qvr_pkg::REG_QUAT_Y] = qvr_pkg::QUAT_V_RESET;
        quat_regs[qvr_pkg::REG_QUAT_Z] = qvr_pkg::QUAT_V_RESET;

        // identity after reset passes the vector through
        add_row(16384, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(16384, 0, 0, 0, 32767, -32768, 1, 1, 32767, -32768, 1, 0);
        add_row(16384, 0, 0, 0, -32768, 32767, -1, 1, -32768, 32767, -1, 0);
        add_row(16384, 0, 0, 0, -1, 1, 12345, 1, -1, 1, 12345, 0);
        // x = -2.0: half turn about x, scaled by four, saturates at the extremes
        add_row(0, -32768, 0, 0, 32767, 32767, -32768, 1, 131068, -131068, 131071, 1);
        add_row(0, -32768, 0, 0, -32768, -32768, 32767, 1, -131072, 131071, -131068, 1);
        add_row(0, -32768, 0, 0, 1, 2, 3, 1, 4, -8, -12, 0);
        // non-unit extremes
        add_row(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, 0, 32767, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 32767, -32768, 32767, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 1, -1, 0, 0, 0, 0, 0, 0);
        // quarter turn about z, not exactly unit
        add_row(11585, 0, 0, 11585, 3, 0, 0, 0, 0, 0, 0, 0);
        add_row(11585, 0, 0, 11585, -5, 7, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 32767, 32767, 32767, 1, 0, 0, 0, 0);
        add_row(0, 0, 16384, 0, 100, -200, 300, 1, -100, -200, -300, 0);
        // w = 0.5 gives v / 4: ties round toward plus infinity
        add_row(8192, 0, 0, 0, 2, -2, 6, 1, 1, 0, 2, 0);
        add_row(8192, 0, 0, 0, -6, 1, -1, 1, -1, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.qw !== quat_regs[qvr_pkg::REG_QUAT_W]
                    || row.qx !== quat_regs[qvr_pkg::REG_QUAT_X]
                    || row.qy !== quat_regs[qvr_pkg::REG_QUAT_Y]
                    || row.qz !== quat_regs[qvr_pkg::REG_QUAT_Z])
                load_quaternion(row.qw, row.qx, row.qy, row.qz);
            send_vector(row.vx, row.vy, row.vz, row.typed, row.want);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            mode = phase % 3;
            foreach (q[k])
                q[k] = random_component(mode);
            load_quaternion(q[qvr_pkg::QW], q[qvr_pkg::QX], q[qvr_pkg::QY], q[qvr_pkg::QZ]);
            steady = (phase == STEADY_PHASE);
            repeat (PHASE_ITEMS)
                send_vector(random_coord(), random_coord(), random_coord(), 1'b0, none);
        end

        steady = 1'b0;
        i_valid <= 1'b0;
        while (rot_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && rot_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
